// ===== hw/rtl/tcp_flow_first_rtt_tracker_defines.svh =====
// Assertion macros shared by the tracker RTL.
// Included by modules that carry concurrent checks; no other dependencies.
`ifndef TCP_FLOW_FIRST_RTT_TRACKER_DEFINES_SVH
`define TCP_FLOW_FIRST_RTT_TRACKER_DEFINES_SVH
`ifndef SYNTHESIS
`define TFRT_ASSERT(lbl, clk, rst, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error("check failed");
`define TFRT_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("check failed");
`else
`define TFRT_ASSERT(lbl, clk, rst, expr)
`define TFRT_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

// ===== hw/rtl/tfrt_pkg.sv =====
// Types and constants for the TCP flow first-RTT tracker.
// No dependencies; used by the interfaces and all modules.
package tfrt_pkg;
  localparam int unsigned MaxFlowsDefault = 256;
  localparam int unsigned KeyW  = 96;
  localparam int unsigned TimeW = 48;
  localparam int unsigned SeqW  = 32;

  typedef struct packed {
    logic        is_valid_tcp;
    logic [31:0] src_addr;
    logic [15:0] src_port;
    logic [31:0] dst_addr;
    logic [15:0] dst_port;
    logic [47:0] time_us;
    logic [15:0] payload_len;
    logic [31:0] seq_num;
    logic [31:0] ack_num;
  } pkt_t;

  typedef struct packed {
    logic        ignored;
    logic [7:0]  own_slot;
    logic        new_flow;
    logic        table_full;
    logic        rtt_found;
    logic [7:0]  rtt_slot;
    logic [47:0] rtt_us;
  } res_t;

  typedef struct packed {
    logic data_seen;
    logic has_rtt;
    logic [TimeW-1:0] send_time;
    logic [SeqW-1:0]  first_seq;
  } rec_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic scan;
    logic own_rd;
    logic own_wr;
    logic rev_rd;
    logic rev_wr;
    logic res_load;
  } ctl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic tcp;
    logic scan_done;
    logic out_busy;
  } sts_t;
endpackage

// ===== hw/rtl/tfrt_pkt_if.sv =====
// Input channel carrying one parsed packet header per transaction.
// Depends on tfrt_pkg.
interface tfrt_pkt_if import tfrt_pkg::*; ();
  logic valid;
  logic ready;
  pkt_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== hw/rtl/tfrt_res_if.sv =====
// Output channel carrying one result per transaction.
// Depends on tfrt_pkg.
interface tfrt_res_if import tfrt_pkg::*; ();
  logic valid;
  logic ready;
  res_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== hw/rtl/tfrt_ctrl.sv =====
// Controller state machine of the tracker: sequences scan, updates and result.
// Depends on tfrt_pkg.
module tfrt_ctrl import tfrt_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  sts_t sts,
  output ctl_t ctl
);
  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_SCAN   = 7'b0000010,
    S_OWN_RD = 7'b0000100,
    S_OWN_WR = 7'b0001000,
    S_REV_RD = 7'b0010000,
    S_REV_WR = 7'b0100000,
    S_RES    = 7'b1000000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    ctl = '0;
    in_ready = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          ctl.load = 1'b1;
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (!sts.tcp) state_next = S_RES;
        else begin
          ctl.scan = 1'b1;
          if (sts.scan_done) state_next = S_OWN_RD;
        end
      end
      S_OWN_RD: begin
        ctl.own_rd = 1'b1;
        state_next = S_OWN_WR;
      end
      S_OWN_WR: begin
        ctl.own_wr = 1'b1;
        state_next = S_REV_RD;
      end
      S_REV_RD: begin
        ctl.rev_rd = 1'b1;
        state_next = S_REV_WR;
      end
      S_REV_WR: begin
        ctl.rev_wr = 1'b1;
        state_next = S_RES;
      end
      S_RES: begin
        if (!sts.out_busy) begin
          ctl.res_load = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end
endmodule

// ===== hw/rtl/tfrt_dp.sv =====
// Datapath of the tracker: key and record memories, scan logic, output register.
// Depends on tfrt_pkg and the assertion macro header.
`include "tcp_flow_first_rtt_tracker_defines.svh"
module tfrt_dp import tfrt_pkg::*; #(
  parameter int unsigned MaxFlows = MaxFlowsDefault
) (
  input  logic clk,
  input  logic rst,
  input  pkt_t pkt,
  input  ctl_t ctl,
  output sts_t sts,
  output logic res_valid,
  input  logic res_ready,
  output res_t res
);
  localparam int unsigned AW = $clog2(MaxFlows);
  localparam int unsigned CW = $clog2(MaxFlows + 1);

  logic [KeyW-1:0] key_mem [MaxFlows];
  rec_t            rec_mem [MaxFlows];

  pkt_t            p;
  logic [KeyW-1:0] fkey, rkey, key_rd;
  rec_t            rec_rd, own_rec;
  logic [CW-1:0]   flow_count, idx;
  logic [AW-1:0]   p_idx, own_slot, rev_slot, rec_addr;
  logic            p_v, own_hit, rev_hit, own_ok, own_new, full;
  logic            rtt_found;
  logic [TimeW-1:0] rtt_us;
  logic            create, rev_fire;

  assign fkey = {p.src_addr, p.src_port, p.dst_addr, p.dst_port};
  assign rkey = {p.dst_addr, p.dst_port, p.src_addr, p.src_port};
  assign create = !own_hit && (flow_count < CW'(MaxFlows));

  assign sts.tcp       = p.is_valid_tcp;
  assign sts.scan_done = (idx == flow_count) && !p_v;
  assign sts.out_busy  = res_valid && !res_ready;

  always_ff @(posedge clk) begin
    if (ctl.load) p <= pkt;
  end

  // Scan: one key read per cycle, compare on the registered data.
  always_ff @(posedge clk) begin
    if (rst) begin
      flow_count <= '0;
    end else if (ctl.own_rd && create) begin
      flow_count <= flow_count + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      idx <= '0;
      p_v <= 1'b0;
      own_hit <= 1'b0;
      rev_hit <= 1'b0;
      own_ok <= 1'b0;
      own_new <= 1'b0;
      full <= 1'b0;
      rtt_found <= 1'b0;
      rtt_us <= '0;
      own_slot <= '0;
      rev_slot <= '0;
    end else if (ctl.scan) begin
      if (idx < flow_count) begin
        key_rd <= key_mem[idx[AW-1:0]];
        p_idx <= idx[AW-1:0];
        idx <= idx + 1'b1;
        p_v <= 1'b1;
      end else begin
        p_v <= 1'b0;
      end
      if (p_v) begin
        if (!own_hit && key_rd == fkey) begin
          own_hit <= 1'b1;
          own_slot <= p_idx;
        end
        if (!rev_hit && key_rd == rkey) begin
          rev_hit <= 1'b1;
          rev_slot <= p_idx;
        end
      end
    end else if (ctl.own_rd) begin
      if (create) begin
        key_mem[flow_count[AW-1:0]] <= fkey;
        own_slot <= flow_count[AW-1:0];
        own_new <= 1'b1;
        own_ok <= 1'b1;
        // A flow that is its own reverse is found by the reverse lookup too.
        if (fkey == rkey) begin
          rev_hit <= 1'b1;
          rev_slot <= flow_count[AW-1:0];
        end
      end else if (own_hit) begin
        own_ok <= 1'b1;
      end else begin
        full <= 1'b1;
      end
    end else if (ctl.rev_wr && rev_fire) begin
      rtt_found <= 1'b1;
      rtt_us <= (p.time_us >= rec_rd.send_time) ? p.time_us - rec_rd.send_time : '0;
    end
  end

  assign rec_addr = ctl.rev_rd ? rev_slot : own_slot;

  always_ff @(posedge clk) begin
    if (ctl.own_rd || ctl.rev_rd) rec_rd <= rec_mem[rec_addr];
  end

  always_comb begin
    own_rec = own_new ? '0 : rec_rd;
    if (!own_rec.data_seen && p.payload_len != '0) begin
      own_rec.data_seen = 1'b1;
      own_rec.send_time = p.time_us;
      own_rec.first_seq = p.seq_num;
    end
  end

  assign rev_fire = rev_hit && rec_rd.data_seen && !rec_rd.has_rtt &&
                    (p.ack_num > rec_rd.first_seq);

  always_ff @(posedge clk) begin
    if (ctl.own_wr && own_ok) begin
      rec_mem[own_slot] <= own_rec;
    end else if (ctl.rev_wr && rev_fire) begin
      rec_mem[rev_slot] <= '{data_seen: 1'b1, has_rtt: 1'b1,
                             send_time: rec_rd.send_time, first_seq: rec_rd.first_seq};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (ctl.res_load) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.res_load) begin
      res.ignored    <= !p.is_valid_tcp;
      res.own_slot   <= (p.is_valid_tcp && own_ok) ? 8'(own_slot) : 8'd0;
      res.new_flow   <= p.is_valid_tcp && own_new;
      res.table_full <= p.is_valid_tcp && full;
      res.rtt_found  <= p.is_valid_tcp && rtt_found;
      res.rtt_slot   <= (p.is_valid_tcp && rtt_found) ? 8'(rev_slot) : 8'd0;
      res.rtt_us     <= p.is_valid_tcp ? rtt_us : '0;
    end
  end

  `TFRT_ASSERT(a_count_max, clk, rst, flow_count <= CW'(MaxFlows))
  `TFRT_ASSERT(a_new_is_own, clk, rst, !own_new || own_ok)
  `TFRT_ASSERT_NEXT(a_create_cnt, clk, rst, ctl.own_rd && create,
    flow_count == $past(flow_count) + 1'b1)
endmodule

// ===== hw/rtl/tcp_flow_first_rtt_tracker.sv =====
// TCP flow first-RTT tracker, top level.
// Input channel pkt takes one parsed packet header per transaction; output
// channel res returns exactly one result per header, in order.
// A header that is not valid TCP yields an ignored result and touches no state.
// Otherwise the flow table is searched for the forward and reverse keys, one
// stored flow per cycle, then the flow records are read and updated.
// For a valid header the table scan through the single key memory read port
// dominates the time in work; ignored headers skip the scan and the record
// updates. One header is in work at a time.
// The result sits in an output register, so a new header is accepted while a
// result still waits; if res is stalled when the next result is ready, the
// controller holds in its result state until the register frees.
// Synchronous reset empties the flow table (fill count to zero) and drops any
// pending result; no clearing pass is needed, since only slots below the fill
// count are ever read and a new slot's record is written when it is created.
// Depends on tfrt_pkg, the channel interfaces, tfrt_ctrl and tfrt_dp.
module tcp_flow_first_rtt_tracker import tfrt_pkg::*; #(
  parameter int unsigned MaxFlows = MaxFlowsDefault
) (
  input logic clk,
  input logic rst,
  tfrt_pkt_if.sink pkt,
  tfrt_res_if.source res
);
  ctl_t ctl;
  sts_t sts;

  tfrt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (pkt.valid),
    .in_ready (pkt.ready),
    .sts      (sts),
    .ctl      (ctl)
  );

  tfrt_dp #(.MaxFlows(MaxFlows)) u_dp (
    .clk       (clk),
    .rst       (rst),
    .pkt       (pkt.data),
    .ctl       (ctl),
    .sts       (sts),
    .res_valid (res.valid),
    .res_ready (res.ready),
    .res       (res.data)
  );
endmodule
